/* src/cpu_alu_pkg.sv */
package cpu_alu_pkg;

  localparam logic [7:0] FLAG_C = 8'h01;
  localparam logic [7:0] FLAG_Z = 8'h02;
  localparam logic [7:0] FLAG_B = 8'h10;
  localparam logic [7:0] FLAG_U = 8'h20;
  localparam logic [7:0] FLAG_V = 8'h40;
  localparam logic [7:0] FLAG_N = 8'h80;

  localparam logic [7:0] RESET_FLAGS = 8'h24;
  localparam logic [7:0] RESET_SP    = 8'hFD;

  typedef enum logic [4:0] {
    OP_LDA, OP_LDX, OP_LDY, OP_STA, OP_AND, OP_EOR, OP_ORA, OP_ADC,
    OP_SBC, OP_ASL_A, OP_ASL_M, OP_LSR_A, OP_LSR_M, OP_ROL_A, OP_ROL_M, OP_ROR_A,
    OP_ROR_M, OP_INC, OP_DEC, OP_INX, OP_INY, OP_DEX, OP_DEY, OP_TAX,
    OP_CMP, OP_CPX, OP_CPY, OP_BIT, OP_PHP, OP_PLP, OP_PLA, OP_BRANCH
  } op_t;

  typedef enum logic [1:0] {
    SH_ASL, SH_LSR, SH_ROL, SH_ROR
  } shift_kind_t;

  typedef struct packed {
    op_t         req_type;
    logic [7:0]  operand;
    logic        branch_taken;
    logic [15:0] offset_address;
  } req_word_t;

  typedef struct packed {
    logic [7:0]  value_out;
    logic        write_memory;
    logic        stack_write;
    logic [8:0]  stack_address;
    logic [7:0]  acc_out;
    logic [7:0]  index_x_out;
    logic [7:0]  index_y_out;
    logic [7:0]  flags_out;
    logic [15:0] next_pc;
    logic [1:0]  extra_cycles;
  } rsp_word_t;

  // returns {carry, result}
  function automatic logic [8:0] shift_byte(shift_kind_t kind, logic [7:0] v, logic cin);
    logic [8:0] r;
    case (kind)
      SH_ASL:  r = {v[7], v[6:0], 1'b0};
      SH_LSR:  r = {v[0], 1'b0, v[7:1]};
      SH_ROL:  r = {v[7], v[6:0], cin};
      SH_ROR:  r = {v[0], cin, v[7:1]};
      default: r = {1'b0, v};
    endcase
    return r;
  endfunction

endpackage

/* src/cpu_alu_req_if.sv */
interface cpu_alu_req_if;
  logic                valid;
  logic                ready;
  cpu_alu_pkg::op_t    req_type;
  logic [7:0]          operand;
  logic                branch_taken;
  logic [15:0]         offset_address;

  modport source (output valid, req_type, operand, branch_taken, offset_address,
                  input ready);
  modport sink   (input valid, req_type, operand, branch_taken, offset_address,
                  output ready);
endinterface

/* src/cpu_alu_rsp_if.sv */
interface cpu_alu_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  value_out;
  logic        write_memory;
  logic        stack_write;
  logic [8:0]  stack_address;
  logic [7:0]  acc_out;
  logic [7:0]  index_x_out;
  logic [7:0]  index_y_out;
  logic [7:0]  flags_out;
  logic [15:0] next_pc;
  logic [1:0]  extra_cycles;

  modport source (output valid, value_out, write_memory, stack_write, stack_address,
                  acc_out, index_x_out, index_y_out, flags_out, next_pc, extra_cycles,
                  input ready);
  modport sink   (input valid, value_out, write_memory, stack_write, stack_address,
                  acc_out, index_x_out, index_y_out, flags_out, next_pc, extra_cycles,
                  output ready);
endinterface

/* src/cpu6502_alu_register_unit.sv */
// channel | dir | word
// req     | in  | req_type, operand, branch_taken, offset_address
// rsp     | out | value_out, write_memory, stack_write, stack_address, A/X/Y/P, next_pc,
//         |     | extra_cycles
// One word per cycle while rsp is not stalled; a req word passes the input register, then the result register.
// The ALU pass and register/flag update sit between the input and result registers.
// Synchronous reset: A=X=Y=0, P=0x24, S=0xFD, both stages empty.
// A stalled rsp holds the result; one more req word is taken into the input register.
module cpu6502_alu_register_unit (
  input  logic          clk,
  input  logic          rst,
  cpu_alu_req_if.sink   req,
  cpu_alu_rsp_if.source rsp
);

  logic                   in_valid;
  cpu_alu_pkg::req_word_t in_word;
  logic                   out_valid;
  cpu_alu_pkg::rsp_word_t out_word;
  logic                   advance;

  logic [7:0] acc, acc_next;
  logic [7:0] idx_x, idx_x_next;
  logic [7:0] idx_y, idx_y_next;
  logic [7:0] flags, flags_next;
  logic [7:0] sp, sp_next;

  cpu_alu_pkg::rsp_word_t      res;
  cpu_alu_pkg::op_t            op;
  logic [7:0]                  m;
  logic [7:0]                  m_add;
  logic [8:0]                  sum;
  logic [4:0]                  shift_idx;
  cpu_alu_pkg::shift_kind_t    kind;
  logic [7:0]                  shift_src;
  logic [8:0]                  shifted;
  logic [7:0]                  cmp_reg;
  logic [8:0]                  diff;
  logic [7:0]                  zn_val;
  logic                        zn_set;
  logic [15:0]                 after;
  logic [15:0]                 target;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
    if (req.ready && req.valid) begin
      in_word.req_type       <= req.req_type;
      in_word.operand        <= req.operand;
      in_word.branch_taken   <= req.branch_taken;
      in_word.offset_address <= req.offset_address;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      acc       <= 8'h00;
      idx_x     <= 8'h00;
      idx_y     <= 8'h00;
      flags     <= cpu_alu_pkg::RESET_FLAGS;
      sp        <= cpu_alu_pkg::RESET_SP;
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
        acc       <= acc_next;
        idx_x     <= idx_x_next;
        idx_y     <= idx_y_next;
        flags     <= flags_next;
        sp        <= sp_next;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_word <= res;
    end
  end

  assign op        = in_word.req_type;
  assign m         = in_word.operand;
  assign m_add     = (op == cpu_alu_pkg::OP_SBC) ? ~m : m;
  assign sum       = {1'b0, acc} + {1'b0, m_add} + {8'h00, flags[0]};
  assign shift_idx = op - cpu_alu_pkg::OP_ASL_A;
  assign kind      = cpu_alu_pkg::shift_kind_t'(shift_idx[2:1]);
  assign shift_src = shift_idx[0] ? m : acc;
  assign shifted   = cpu_alu_pkg::shift_byte(kind, shift_src, flags[0]);
  assign cmp_reg   = (op == cpu_alu_pkg::OP_CPX) ? idx_x :
                     (op == cpu_alu_pkg::OP_CPY) ? idx_y : acc;
  assign diff      = {1'b0, cmp_reg} - {1'b0, m};
  assign after     = in_word.offset_address + 16'd1;
  assign target    = after + {{8{m[7]}}, m};

  always_comb begin
    acc_next   = acc;
    idx_x_next = idx_x;
    idx_y_next = idx_y;
    flags_next = flags;
    sp_next    = sp;
    zn_val     = 8'h00;
    zn_set     = 1'b0;
    res        = '0;
    res.stack_address = {1'b1, sp};
    res.next_pc       = after;

    case (op)
      cpu_alu_pkg::OP_LDA: begin
        acc_next = m; zn_val = m; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_LDX: begin
        idx_x_next = m; zn_val = m; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_LDY: begin
        idx_y_next = m; zn_val = m; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_STA: begin
        res.value_out = acc; res.write_memory = 1'b1;
      end
      cpu_alu_pkg::OP_AND: begin
        acc_next = acc & m; zn_val = acc & m; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_EOR: begin
        acc_next = acc ^ m; zn_val = acc ^ m; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_ORA: begin
        acc_next = acc | m; zn_val = acc | m; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_ADC, cpu_alu_pkg::OP_SBC: begin
        acc_next = sum[7:0];
        zn_val   = sum[7:0];
        zn_set   = 1'b1;
        flags_next[0] = sum[8];
        flags_next[6] = (m_add[7] ^ sum[7]) & (acc[7] ^ sum[7]);
      end
      cpu_alu_pkg::OP_ASL_A, cpu_alu_pkg::OP_LSR_A,
      cpu_alu_pkg::OP_ROL_A, cpu_alu_pkg::OP_ROR_A: begin
        acc_next = shifted[7:0]; zn_val = shifted[7:0]; zn_set = 1'b1;
        flags_next[0] = shifted[8];
      end
      cpu_alu_pkg::OP_ASL_M, cpu_alu_pkg::OP_LSR_M,
      cpu_alu_pkg::OP_ROL_M, cpu_alu_pkg::OP_ROR_M: begin
        res.value_out = shifted[7:0]; res.write_memory = 1'b1;
        zn_val = shifted[7:0]; zn_set = 1'b1;
        flags_next[0] = shifted[8];
      end
      cpu_alu_pkg::OP_INC: begin
        res.value_out = m + 8'd1; res.write_memory = 1'b1;
        zn_val = m + 8'd1; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_DEC: begin
        res.value_out = m - 8'd1; res.write_memory = 1'b1;
        zn_val = m - 8'd1; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_INX: begin
        idx_x_next = idx_x + 8'd1; zn_val = idx_x + 8'd1; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_INY: begin
        idx_y_next = idx_y + 8'd1; zn_val = idx_y + 8'd1; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_DEX: begin
        idx_x_next = idx_x - 8'd1; zn_val = idx_x - 8'd1; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_DEY: begin
        idx_y_next = idx_y - 8'd1; zn_val = idx_y - 8'd1; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_TAX: begin
        idx_x_next = acc; zn_val = acc; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_CMP, cpu_alu_pkg::OP_CPX, cpu_alu_pkg::OP_CPY: begin
        flags_next[0] = !diff[8];
        zn_val = diff[7:0]; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_BIT: begin
        flags_next[1] = (acc & m) == 8'h00;
        flags_next[7] = m[7];
        flags_next[6] = m[6];
      end
      cpu_alu_pkg::OP_PHP: begin
        res.value_out   = flags | cpu_alu_pkg::FLAG_B | cpu_alu_pkg::FLAG_U;
        res.stack_write = 1'b1;
        sp_next         = sp - 8'd1;
      end
      cpu_alu_pkg::OP_PLP: begin
        sp_next           = sp + 8'd1;
        res.stack_address = {1'b1, sp + 8'd1};
        flags_next        = (m & ~cpu_alu_pkg::FLAG_B) | cpu_alu_pkg::FLAG_U;
      end
      cpu_alu_pkg::OP_PLA: begin
        sp_next           = sp + 8'd1;
        res.stack_address = {1'b1, sp + 8'd1};
        acc_next = m; zn_val = m; zn_set = 1'b1;
      end
      cpu_alu_pkg::OP_BRANCH: begin
        if (in_word.branch_taken) begin
          res.next_pc      = target;
          res.extra_cycles = (target[15:8] != after[15:8]) ? 2'd2 : 2'd1;
        end
      end
      default: begin
      end
    endcase

    if (zn_set) begin
      flags_next[1] = zn_val == 8'h00;
      flags_next[7] = zn_val[7];
    end

    res.acc_out     = acc_next;
    res.index_x_out = idx_x_next;
    res.index_y_out = idx_y_next;
    res.flags_out   = flags_next;
  end

  assign rsp.valid         = out_valid;
  assign rsp.value_out     = out_word.value_out;
  assign rsp.write_memory  = out_word.write_memory;
  assign rsp.stack_write   = out_word.stack_write;
  assign rsp.stack_address = out_word.stack_address;
  assign rsp.acc_out       = out_word.acc_out;
  assign rsp.index_x_out   = out_word.index_x_out;
  assign rsp.index_y_out   = out_word.index_y_out;
  assign rsp.flags_out     = out_word.flags_out;
  assign rsp.next_pc       = out_word.next_pc;
  assign rsp.extra_cycles  = out_word.extra_cycles;

  a_unused_flag_set: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> rsp.flags_out[5])
    else $error("unused status bit cleared");

  a_push_has_break: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.stack_write) |-> (rsp.value_out[5:4] == 2'b11))
    else $error("pushed status lacks B/U");

  a_one_target: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.stack_write && rsp.write_memory))
    else $error("stack push and memory write together");

  a_penalty_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.extra_cycles != 2'd3))
    else $error("branch penalty out of range");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> ($stable(acc) && $stable(flags) && $stable(sp)))
    else $error("register state changed without a word");

endmodule
